@@ hdl/lcg_pkg.sv @@
// shared types, constants and the gamma table builder for the led chain serializer
// no dependencies; imported by every module of the block
package lcg_pkg;

  localparam int unsigned NUM_LANES        = 6;
  localparam int unsigned WORD_BITS        = 16;
  localparam int unsigned CODE_BITS        = 8;
  localparam int unsigned ROM_DEPTH        = 256;
  localparam int unsigned CNT_W            = 4;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned CHAIN_LEN_W      = 7;
  localparam int unsigned CHAIN_MAX        = 64;
  localparam int unsigned CHAIN_LEN_RESET  = 22;
  localparam int unsigned PWM_BITS_DEFAULT = 16;

  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // lane order of the packed word vector
  localparam int unsigned LANE_UPPER_RED   = 0;
  localparam int unsigned LANE_UPPER_GREEN = 1;
  localparam int unsigned LANE_UPPER_BLUE  = 2;
  localparam int unsigned LANE_LOWER_RED   = 3;
  localparam int unsigned LANE_LOWER_GREEN = 4;
  localparam int unsigned LANE_LOWER_BLUE  = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [NUM_LANES-1:0][WORD_BITS-1:0] lane_words_t;
  typedef logic [ROM_DEPTH-1:0][WORD_BITS-1:0] gamma_rom_t;

  // load request from the top level to the serializer
  typedef struct packed {
    logic             load;
    logic             latch_all;
    logic             last_chip;
    logic [CNT_W-1:0] pulses_m1;
  } load_req_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // series term divisor, one literal per term
  function automatic logic [63:0] div_term(input logic [63:0] value, input int n);
    logic [63:0] res;
    case (n)
      1:       res = value;
      2:       res = value / 64'd2;
      3:       res = value / 64'd3;
      4:       res = value / 64'd4;
      5:       res = value / 64'd5;
      6:       res = value / 64'd6;
      7:       res = value / 64'd7;
      8:       res = value / 64'd8;
      9:       res = value / 64'd9;
      10:      res = value / 64'd10;
      11:      res = value / 64'd11;
      12:      res = value / 64'd12;
      13:      res = value / 64'd13;
      default: res = value / 64'd14;
    endcase
    return res;
  endfunction

  // one gamma entry in q30 fixed point, evaluated at elaboration
  function automatic word_t gamma_entry(input int unsigned x, input int unsigned pwm_bits);
    logic [63:0]        b;
    logic [63:0]        m;
    logic [63:0]        f;
    logic [63:0]        nl;
    logic [63:0]        y;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        t;
    logic [63:0]        term;
    logic [63:0]        full;
    logic [63:0]        k;
    logic signed [63:0] sum;
    logic               dark;
    full = (64'd1 << pwm_bits) - 64'd1;
    dark = (x <= 10);
    if (dark) begin
      b = ((64'(x) * 64'd100) << 30) / 64'd329460;
    end else begin
      b = ((64'(x) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
    end
    if (b == 64'd0) return '0;
    if (b > Q30_ONE) b = Q30_ONE;
    m = b;
    k = 64'd0;
    while (m < Q30_ONE) begin
      m = m << 1;
      k = k + 64'd1;
    end
    f = 64'd0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (Q30_ONE << 1)) begin
        m = m >> 1;
        f = f | (64'd1 << (29 - i));
      end
    end
    nl = (k << 30) - f;
    if (dark) begin
      y = (nl * 64'd11) / 64'd10;
    end else begin
      y = (nl * 64'd264) / 64'd100;
    end
    q = y >> 30;
    r = y & (Q30_ONE - 64'd1);
    if (q >= 64'd32) return '0;
    t = (r * LN2_Q30) >> 30;
    sum = $signed(Q30_ONE);
    term = Q30_ONE;
    for (int n = 1; n <= 14; n++) begin
      term = div_term((term * t) >> 30, n);
      if ((n % 2) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
    return word_t'(($unsigned(sum) * full) >> (64'd30 + q));
  endfunction

  function automatic gamma_rom_t build_gamma_rom(input int unsigned pwm_bits);
    gamma_rom_t rom;
    for (int unsigned x = 0; x < ROM_DEPTH; x++) begin
      rom[x] = gamma_entry(x, pwm_bits);
    end
    return rom;
  endfunction

endpackage

@@ hdl/lcg_gamma_rom.sv @@
// constant gamma table, srgb code to pwm word
// depends on lcg_pkg for the table builder
module lcg_gamma_rom
  import lcg_pkg::*;
#(
  parameter int unsigned PWM_BITS = PWM_BITS_DEFAULT
) (
  input  logic [CODE_BITS-1:0] code,
  output word_t                word
);

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom(PWM_BITS);

  assign word = GAMMA_ROM[code];

endmodule

@@ hdl/lcg_serializer.sv @@
// six msb-first shift registers with pulse counter and latch/last flags
// depends on lcg_pkg for lane words and the load request struct
module lcg_serializer
  import lcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  load_req_t            req,
  input  lane_words_t          words,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [NUM_LANES-1:0] lane_bits,
  output logic                 latch,
  output logic                 last
);

  lane_words_t      shreg;
  logic [CNT_W-1:0] remaining;
  logic             latch_all;
  logic             last_chip;
  logic             fire;

  assign fire = out_valid && !out_stall;
  assign last = (remaining == '0);
  assign latch = latch_all || (last_chip && last);

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lane_bits[j] = shreg[j][WORD_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.load) begin
      out_valid <= 1'b1;
    end else if (fire && last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      shreg     <= words;
      remaining <= req.pulses_m1;
      latch_all <= req.latch_all;
      last_chip <= req.last_chip;
    end else if (fire) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        shreg[j] <= {shreg[j][WORD_BITS-2:0], 1'b0};
      end
      remaining <= remaining - 1'b1;
    end
  end

endmodule

@@ hdl/led_chain_gamma_serializer_top.sv @@
// top level of the led driver chain serializer with srgb gamma
// depends on lcg_pkg, lcg_gamma_rom and lcg_serializer
//
// the first pulse of an item is offered in the cycle after the request is taken
// throughput: a pixel request gives 16 pulses, one per cycle while out_stall is low;
//   a command request gives pulse_count pulses; the next request is taken in the
//   cycle the final pulse leaves
// reset: synchronous, clears the chain position, loads chain length 22, drops out_valid
module led_chain_gamma_serializer_top
  import lcg_pkg::*;
#(
  parameter int unsigned PWM_BITS = PWM_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write, chain length
  input  logic                   cfg_wr_en,
  input  logic [CHAIN_LEN_W-1:0] cfg_wr_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [CODE_BITS-1:0]   upper_red,
  input  logic [CODE_BITS-1:0]   upper_green,
  input  logic [CODE_BITS-1:0]   upper_blue,
  input  logic [CODE_BITS-1:0]   lower_red,
  input  logic [CODE_BITS-1:0]   lower_green,
  input  logic [CODE_BITS-1:0]   lower_blue,
  input  logic [CNT_W-1:0]       pulse_count,
  // pulse channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   upper_red_bit,
  output logic                   upper_green_bit,
  output logic                   upper_blue_bit,
  output logic                   lower_red_bit,
  output logic                   lower_green_bit,
  output logic                   lower_blue_bit,
  output logic                   latch,
  output logic                   last
);

  logic [CHAIN_LEN_W-1:0] chain_length;
  logic [POS_W-1:0]       chain_position;
  logic [POS_W-1:0]       last_pos;
  logic                   last_chip;
  logic                   in_fire;
  logic                   is_pixel;
  lane_words_t            rom_words;
  lane_words_t            load_words;
  load_req_t              req;
  logic [NUM_LANES-1:0]   lane_bits;
  logic [NUM_LANES-1:0][CODE_BITS-1:0] codes;

  // serializer frees up in the cycle its final pulse is taken
  assign in_stall = out_valid && !(!out_stall && last);
  assign in_fire  = in_valid && !in_stall;
  assign is_pixel = (operation == OP_PIXEL);

  // chain length register
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= CHAIN_LEN_W'(CHAIN_LEN_RESET);
    end else if (cfg_wr_en) begin
      chain_length <= cfg_wr_data;
    end
  end

  // index of the last chip, length clamped to 1..64
  always_comb begin
    if (chain_length == '0) begin
      last_pos = '0;
    end else if (chain_length > CHAIN_LEN_W'(CHAIN_MAX)) begin
      last_pos = POS_W'(CHAIN_MAX - 1);
    end else begin
      last_pos = POS_W'(chain_length - 1'b1);
    end
  end

  // a position past the end after a shorter length counts as the last chip
  assign last_chip = (chain_position >= last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_position <= '0;
    end else if (in_fire && is_pixel) begin
      chain_position <= last_chip ? '0 : chain_position + 1'b1;
    end
  end

  // gamma lookups, one rom per data line
  assign codes[LANE_UPPER_RED]   = upper_red;
  assign codes[LANE_UPPER_GREEN] = upper_green;
  assign codes[LANE_UPPER_BLUE]  = upper_blue;
  assign codes[LANE_LOWER_RED]   = lower_red;
  assign codes[LANE_LOWER_GREEN] = lower_green;
  assign codes[LANE_LOWER_BLUE]  = lower_blue;

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_rom
    lcg_gamma_rom #(
      .PWM_BITS(PWM_BITS)
    ) u_rom (
      .code(codes[j]),
      .word(rom_words[j])
    );
  end

  // command requests shift zeros with the latch held high
  assign load_words = is_pixel ? rom_words : '0;

  always_comb begin
    req.load      = in_fire && (is_pixel || (pulse_count != '0));
    req.latch_all = !is_pixel;
    req.last_chip = is_pixel && last_chip;
    req.pulses_m1 = is_pixel ? CNT_W'(WORD_BITS - 1) : pulse_count - 1'b1;
  end

  lcg_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .words    (load_words),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .lane_bits(lane_bits),
    .latch    (latch),
    .last     (last)
  );

  assign upper_red_bit   = lane_bits[LANE_UPPER_RED];
  assign upper_green_bit = lane_bits[LANE_UPPER_GREEN];
  assign upper_blue_bit  = lane_bits[LANE_UPPER_BLUE];
  assign lower_red_bit   = lane_bits[LANE_LOWER_RED];
  assign lower_green_bit = lane_bits[LANE_LOWER_GREEN];
  assign lower_blue_bit  = lane_bits[LANE_LOWER_BLUE];

endmodule
